// ===== rtl/icc_pkg.sv =====
// Shared types, codes and small arithmetic helpers for the ISBN checker/converter.
package icc_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOWX  = 8'h78;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // Symbol value that stands for X
  localparam logic [3:0] SYM_X = 4'd10;

  // Mode register codes
  localparam logic [1:0] MODE_VALIDATE = 2'd0;
  localparam logic [1:0] MODE_TO13     = 2'd1;
  localparam logic [1:0] MODE_TO10     = 2'd2;

  // Length class codes
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TEN  = 2'd1;
  localparam logic [1:0] KIND_THIR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LENGTH = 2'd1;
  localparam logic [1:0] ERR_CHECK  = 2'd2;
  localparam logic [1:0] ERR_PREFIX = 2'd3;

  // Weighted sum of the 978 prefix, mod 10
  localparam logic [3:0] PREFIX_SUM13 = 4'd8;

  // Kind of result run
  typedef enum logic [1:0] {
    RUN_SINGLE = 2'd0,
    RUN_13     = 2'd1,
    RUN_10     = 2'd2
  } run_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic decide;
    logic advance;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_last;
  } stat_t;

  // Reduce a value below 121 mod 11 by conditional subtraction
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'd11) r = r - 7'd11;
    return r[3:0];
  endfunction

  // Reduce a value below 40 mod 10 by conditional subtraction
  function automatic logic [3:0] mod10(input logic [5:0] x);
    logic [5:0] r;
    r = x;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

  // ISBN-10 character of a symbol value
  function automatic logic [7:0] ten_char(input logic [3:0] v);
    return (v == SYM_X) ? CH_UPX : CH_ZERO + {4'd0, v};
  endfunction

  // Characters of the 978 prefix
  function automatic logic [7:0] prefix_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = CH_NINE;
      2'd1:    c = CH_SEVEN;
      default: c = CH_EIGHT;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/icc_if.sv =====
// Channel interfaces: character input, result output and mode write.
interface icc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface icc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       valid_res;
  logic [1:0] kind;
  logic [1:0] error;
  modport source (output valid, output out_char, output out_last, output valid_res,
                  output kind, output error, input ready);
  modport sink   (input valid, input out_char, input out_last, input valid_res,
                  input kind, input error, output ready);
endinterface

interface icc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// ===== rtl/isbn_check_and_convert_core.sv =====
// Top level of the ISBN-10/ISBN-13 checker and converter.
//
// in_bus carries one ASCII character per request, with last on the final
// character of an ISBN. Digits, X and x are kept; everything else is dropped.
// cfg_bus writes the 2-bit mode (validate, 10 to 13, 13 to 10); it is always
// ready. It is to be written only while the block is idle; the block itself
// does not enforce this. out_bus carries results: one verdict or error
// request, or a run of 13 (ISBN-13) or 10 (ISBN-10) characters, the final one
// marked out_last. Characters are taken one per cycle while in_bus.ready is
// high. After the last character is accepted the controller passes through
// the verdict state, which loads the first result, and then offers it from the
// emit state; results then leave one per cycle while out_bus.ready is high,
// and a stall holds the current result. in_bus.ready stays low from the last
// character until the final result is taken. The controller state machine sets
// this pace. Reset clears the run state and returns mode to validate.
module isbn_check_and_convert_core (
  input  logic      clk,
  input  logic      rst_n,
  icc_in_if.sink    in_bus,
  icc_out_if.source out_bus,
  icc_cfg_if.sink   cfg_bus
);

  icc_pkg::cmd_t  cmd;
  icc_pkg::stat_t stat;

  // Mode writes are always taken
  assign cfg_bus.ready = 1'b1;

  icc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_last   (in_bus.last),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .cmd       (cmd)
  );

  icc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_ch     (in_bus.ch),
    .cfg_valid (cfg_bus.valid),
    .cfg_mode  (cfg_bus.mode),
    .out_char  (out_bus.out_char),
    .out_last  (out_bus.out_last),
    .valid_res (out_bus.valid_res),
    .kind      (out_bus.kind),
    .error     (out_bus.error)
  );

endmodule

// ===== rtl/icc_ctrl.sv =====
// Controller: sequences accumulation, verdict and result emission.
module icc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  logic          out_ready,
  input  icc_pkg::stat_t stat,
  output logic          in_ready,
  output logic          out_valid,
  output icc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_ACCUM  = 3'b001,
    ST_DECIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Handshake outputs follow the state
  assign in_ready  = (state_r == ST_ACCUM);
  assign out_valid = (state_r == ST_EMIT);

  // Issue commands and pick the next state
  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.decide  = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      ST_ACCUM: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (stat.out_last) state_nxt = ST_ACCUM;
          else cmd.advance = 1'b1;
        end
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_ACCUM;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/icc_datapath.sv =====
// Datapath: symbol store, running check sums, verdict and result registers.
module icc_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  icc_pkg::cmd_t  cmd,
  output icc_pkg::stat_t stat,
  input  logic [7:0]     in_ch,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_mode,
  output logic [7:0]     out_char,
  output logic           out_last,
  output logic           valid_res,
  output logic [1:0]     kind,
  output logic [1:0]     error
);

  logic [1:0] mode_r;
  logic [3:0] count_r, count_nxt;
  logic [3:0] sum10_r, sum10_nxt;
  logic [3:0] sum13_r, sum13_nxt;
  logic [3:0] csum10_r, csum10_nxt;
  logic [3:0] csum13_r, csum13_nxt;
  logic       misx_r, misx_nxt;
  logic [3:0] store_r [13];

  logic       is_digit, is_x, keep;
  logic [3:0] sym;
  logic [3:0] w10, w13a, w13b, wc10;
  logic [7:0] p10, p13a, p13b, pc10;

  logic [1:0]          kd_c;
  logic [3:0]          chk10_c, chk13_c, c13_c, c10_c;
  logic                valid_c, prefix_ok_c;
  logic [7:0]          chkc_c, single_char_c, c13ch_c, c10ch_c;
  logic [1:0]          err_c;
  icc_pkg::run_t       run_c;

  icc_pkg::run_t run_r, sel_run;
  logic [3:0]    idx_r, sel_idx, sym_addr;
  logic [7:0]    c13ch_r, c10ch_r, sel_c13, sel_c10, sel_char;
  logic [3:0]    sel_sym;
  logic          sel_last;
  logic [7:0]    out_char_r;
  logic          out_last_r, valid_res_r;
  logic [1:0]    kind_r, error_r;

  // Classify the incoming character
  assign is_digit = (in_ch >= icc_pkg::CH_ZERO) && (in_ch <= icc_pkg::CH_NINE);
  assign is_x     = (in_ch == icc_pkg::CH_UPX) || (in_ch == icc_pkg::CH_LOWX);
  assign keep     = is_digit || is_x;
  assign sym      = is_digit ? in_ch[3:0] : icc_pkg::SYM_X;

  // Position weights and products
  assign w10  = 4'd10 - count_r;
  assign w13a = count_r[0] ? 4'd1 : 4'd3;
  assign w13b = count_r[0] ? 4'd3 : 4'd1;
  assign wc10 = 4'd13 - count_r;
  assign p10  = {4'd0, sym} * {4'd0, w10};
  assign p13a = {4'd0, sym} * {4'd0, w13a};
  assign p13b = {4'd0, sym} * {4'd0, w13b};
  assign pc10 = {4'd0, sym} * {4'd0, wc10};

  // Advance running sums on a kept symbol, clear them after the verdict
  always_comb begin
    count_nxt  = count_r;
    sum10_nxt  = sum10_r;
    sum13_nxt  = sum13_r;
    csum10_nxt = csum10_r;
    csum13_nxt = csum13_r;
    misx_nxt   = misx_r;
    if (cmd.decide) begin
      count_nxt  = 4'd0;
      sum10_nxt  = 4'd0;
      sum13_nxt  = 4'd0;
      csum10_nxt = 4'd0;
      csum13_nxt = icc_pkg::PREFIX_SUM13;
      misx_nxt   = 1'b0;
    end else if (cmd.accept && keep) begin
      if ((sym == icc_pkg::SYM_X) && (count_r != 4'd9)) misx_nxt = 1'b1;
      if (count_r < 4'd9) begin
        sum10_nxt  = icc_pkg::mod11(p10[6:0] + {3'd0, sum10_r});
        csum13_nxt = icc_pkg::mod10(p13a[5:0] + {2'd0, csum13_r});
      end
      if (count_r < 4'd12)
        sum13_nxt = icc_pkg::mod10(p13b[5:0] + {2'd0, sum13_r});
      if ((count_r >= 4'd3) && (count_r < 4'd12))
        csum10_nxt = icc_pkg::mod11(pc10[6:0] + {3'd0, csum10_r});
      if (count_r != 4'd15) count_nxt = count_r + 4'd1;
    end
  end

  // Hold run state and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= icc_pkg::MODE_VALIDATE;
      count_r  <= 4'd0;
      sum10_r  <= 4'd0;
      sum13_r  <= 4'd0;
      csum10_r <= 4'd0;
      csum13_r <= icc_pkg::PREFIX_SUM13;
      misx_r   <= 1'b0;
    end else begin
      if (cfg_valid) mode_r <= cfg_mode;
      count_r  <= count_nxt;
      sum10_r  <= sum10_nxt;
      sum13_r  <= sum13_nxt;
      csum10_r <= csum10_nxt;
      csum13_r <= csum13_nxt;
      misx_r   <= misx_nxt;
    end
  end

  // Store kept symbols, up to thirteen
  always_ff @(posedge clk) begin
    if (cmd.accept && keep && (count_r < 4'd13)) store_r[count_r] <= sym;
  end

  // Verdict on the finished ISBN
  assign chk10_c = (sum10_r == 4'd0) ? 4'd0 : 4'd11 - sum10_r;
  assign chk13_c = (sum13_r == 4'd0) ? 4'd0 : 4'd10 - sum13_r;
  assign c10_c   = (csum10_r == 4'd0) ? 4'd0 : 4'd11 - csum10_r;
  assign c13_c   = (csum13_r == 4'd0) ? 4'd0 : 4'd10 - csum13_r;
  assign c10ch_c = icc_pkg::ten_char(c10_c);
  assign c13ch_c = icc_pkg::CH_ZERO + {4'd0, c13_c};
  assign prefix_ok_c = (store_r[0] == 4'd9) && (store_r[1] == 4'd7) && (store_r[2] == 4'd8);

  always_comb begin
    kd_c    = icc_pkg::KIND_NONE;
    valid_c = 1'b0;
    chkc_c  = icc_pkg::CH_NONE;
    if (count_r == 4'd10) begin
      kd_c    = icc_pkg::KIND_TEN;
      chkc_c  = icc_pkg::ten_char(chk10_c);
      valid_c = !misx_r && (store_r[9] == chk10_c);
    end else if (count_r == 4'd13) begin
      kd_c    = icc_pkg::KIND_THIR;
      chkc_c  = icc_pkg::CH_ZERO + {4'd0, chk13_c};
      valid_c = !misx_r && (store_r[9] != icc_pkg::SYM_X) && (store_r[12] == chk13_c);
    end
  end

  // Choose the result run and its error
  always_comb begin
    run_c         = icc_pkg::RUN_SINGLE;
    err_c         = icc_pkg::ERR_NONE;
    single_char_c = icc_pkg::CH_NONE;
    if ((mode_r == icc_pkg::MODE_TO13) || (mode_r == icc_pkg::MODE_TO10)) begin
      if (kd_c != mode_r) err_c = icc_pkg::ERR_LENGTH;
      else if (!valid_c) err_c = icc_pkg::ERR_CHECK;
      else if (mode_r == icc_pkg::MODE_TO13) run_c = icc_pkg::RUN_13;
      else if (!prefix_ok_c) err_c = icc_pkg::ERR_PREFIX;
      else run_c = icc_pkg::RUN_10;
    end else begin
      if (kd_c == icc_pkg::KIND_NONE) err_c = icc_pkg::ERR_LENGTH;
      else begin
        single_char_c = chkc_c;
        err_c = valid_c ? icc_pkg::ERR_NONE : icc_pkg::ERR_CHECK;
      end
    end
  end

  // Select the run position to load: first at the verdict, next on advance
  assign sel_run  = cmd.decide ? run_c : run_r;
  assign sel_idx  = cmd.decide ? 4'd0 : idx_r + 4'd1;
  assign sel_c13  = cmd.decide ? c13ch_c : c13ch_r;
  assign sel_c10  = cmd.decide ? c10ch_c : c10ch_r;
  assign sym_addr = (sel_run == icc_pkg::RUN_13) ? sel_idx - 4'd3 : sel_idx + 4'd3;
  assign sel_sym  = (sym_addr < 4'd13) ? store_r[sym_addr] : 4'd0;

  always_comb begin
    case (sel_run)
      icc_pkg::RUN_13: begin
        if (sel_idx < 4'd3) sel_char = icc_pkg::prefix_char(sel_idx[1:0]);
        else if (sel_idx < 4'd12) sel_char = icc_pkg::CH_ZERO + {4'd0, sel_sym};
        else sel_char = sel_c13;
        sel_last = (sel_idx == 4'd12);
      end
      icc_pkg::RUN_10: begin
        if (sel_idx < 4'd9) sel_char = icc_pkg::CH_ZERO + {4'd0, sel_sym};
        else sel_char = sel_c10;
        sel_last = (sel_idx == 4'd9);
      end
      default: begin
        sel_char = single_char_c;
        sel_last = 1'b1;
      end
    endcase
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      run_r       <= run_c;
      c13ch_r     <= c13ch_c;
      c10ch_r     <= c10ch_c;
      valid_res_r <= valid_c;
      kind_r      <= kd_c;
      error_r     <= err_c;
    end
    if (cmd.decide || cmd.advance) begin
      idx_r      <= sel_idx;
      out_char_r <= sel_char;
      out_last_r <= sel_last;
    end
  end

  assign out_char      = out_char_r;
  assign out_last      = out_last_r;
  assign valid_res     = valid_res_r;
  assign kind          = kind_r;
  assign error         = error_r;
  assign stat.out_last = out_last_r;

endmodule

// ===== rtl/icc_checker.sv =====
// Port-level checks for the ISBN checker/converter, bound to the top level.
module icc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [1:0] error
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Input and output never open together
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // The first result is offered after the verdict state that follows the last character
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |-> ##2 out_valid)
    else $error("no result after final character");

  // Taking the final result reopens the input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("input not reopened after final result");

  // An error result is always the only one of its run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error != icc_pkg::ERR_NONE) |-> out_last)
    else $error("error result not marked final");

endmodule

bind isbn_check_and_convert_core icc_checker u_icc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.last),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_last  (out_bus.out_last),
  .error     (out_bus.error)
);
